// File: hw/rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

    // Default widths of the position counters.
    localparam int LINE_BITS_DEF     = 20;
    localparam int COLUMN_BITS_DEF   = 16;
    localparam int OFFSET_BITS_DEF   = 24;
    localparam int KEYWORD_CHARS_DEF = 6;

    // Fixed field widths.
    localparam int CFG_W    = 20;
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 5;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 8;
    localparam int TUSER_W  = KIND_W + STATUS_W;

    // Longest keyword; keyword compare looks at this many buffered characters.
    localparam int KW_MATCH_CHARS = 6;

    // Results of one character that wait between scanner and output stage.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] FIRST_LINE_RST = CFG_W'(1);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_EQ,
        MODE_BANG,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_DISCARD
    } t_scan_mode;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_EOF    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd1;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd2;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd4;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd5;
    localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_STAR   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd9;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd10;
    localparam logic [KIND_W-1:0] KIND_EQEQ   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_NOTEQ  = 5'd12;
    localparam logic [KIND_W-1:0] KIND_LT     = 5'd13;
    localparam logic [KIND_W-1:0] KIND_GT     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_DOT    = 5'd15;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_AMP    = 5'd17;
    localparam logic [KIND_W-1:0] KIND_PIPE   = 5'd18;
    localparam logic [KIND_W-1:0] KIND_BANG   = 5'd19;
    localparam logic [KIND_W-1:0] KIND_CARET  = 5'd20;
    localparam logic [KIND_W-1:0] KIND_PCT    = 5'd21;
    localparam logic [KIND_W-1:0] KIND_FUNC   = 5'd22;
    localparam logic [KIND_W-1:0] KIND_RETURN = 5'd23;
    localparam logic [KIND_W-1:0] KIND_TYPE   = 5'd24;
    localparam logic [KIND_W-1:0] KIND_STRING = 5'd25;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd26;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd27;
    localparam logic [KIND_W-1:0] KIND_COLON  = 5'd28;

    // Result status.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNTERM   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_CHAR = 2'd2;

    // Characters with a role of their own.
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQ      = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;

    function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2C:   k = KIND_COMMA;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h2E:   k = KIND_DOT;
            8'h3B:   k = KIND_SEMI;
            8'h26:   k = KIND_AMP;
            8'h7C:   k = KIND_PIPE;
            8'h5E:   k = KIND_CARET;
            8'h25:   k = KIND_PCT;
            8'h3A:   k = KIND_COLON;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Word holds the first buffered character in its top byte.
    function automatic logic [KIND_W-1:0] ident_kind(
        input logic [8*KW_MATCH_CHARS-1:0] w,
        input logic [LEN_W-1:0]            len,
        input logic                        ovf
    );
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        if (!ovf) begin
            if (len == 8'd4 && w[47:16] == "func") begin
                k = KIND_FUNC;
            end else if ((len == 8'd3 && w[47:24] == "int")
                      || (len == 8'd6 && w == "string")
                      || (len == 8'd4 && w[47:16] == "bool")) begin
                k = KIND_TYPE;
            end else if (len == 8'd6 && w == "return") begin
                k = KIND_RETURN;
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stt_front.sv
`default_nettype none

module stt_front #(
    parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS   = stt_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
    parameter int RES_W         = stt_pkg::TUSER_W + LINE_BITS + COLUMN_BITS
                                  + OFFSET_BITS + 2 * stt_pkg::LEN_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [stt_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [stt_pkg::CHAR_W-1:0]  i_ch,
    input  wire logic                        i_eot,
    output logic                             o_push,
    output logic [2*RES_W:0]                 o_entry,
    input  wire logic                        i_q_full
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [stt_pkg::LEN_W-1:0] LEN_MAX = {stt_pkg::LEN_W{1'b1}};

    logic [stt_pkg::CFG_W-1:0]   r_first_line;
    stt_pkg::t_scan_mode         r_mode, n_mode;
    logic [LINE_BITS-1:0]        r_line, n_line, line_eff, cfg_line;
    logic [COLUMN_BITS-1:0]      r_col, n_col, r_tok_col, n_tok_col;
    logic [OFFSET_BITS-1:0]      r_off, n_off, r_tok_off, n_tok_off, off_inc;
    logic [stt_pkg::LEN_W-1:0]   r_len, n_len, len_inc;
    logic                        r_ovf, n_ovf;
    logic [stt_pkg::CHAR_W-1:0]  r_kw [KEYWORD_CHARS];
    logic                        kw_wr;
    logic [stt_pkg::LEN_W-1:0]   kw_sel;
    logic [8*stt_pkg::KW_MATCH_CHARS-1:0] kw_word;
    logic [stt_pkg::KIND_W-1:0]  id_kind;
    logic                        accept, handled, newline, a_vld, b_vld, ident_ch;
    logic [RES_W-1:0]            res_a, res_b;

    function automatic logic [RES_W-1:0] mk(
        input logic [stt_pkg::KIND_W-1:0]   kind,
        input logic [stt_pkg::STATUS_W-1:0] status,
        input logic [LINE_BITS-1:0]         line,
        input logic [COLUMN_BITS-1:0]       col,
        input logic [OFFSET_BITS-1:0]       off,
        input logic [stt_pkg::LEN_W-1:0]    len,
        input logic [stt_pkg::CHAR_W-1:0]   bad
    );
        return {bad, len, off, col, line, status, kind};
    endfunction

    assign accept   = i_valid && o_ready;
    assign o_ready  = !i_q_full;
    assign cfg_line = LINE_BITS'(r_first_line);
    // A fresh text takes its first line number from the register.
    assign line_eff = (r_off == '0 && r_mode == stt_pkg::MODE_IDLE) ? cfg_line : r_line;
    assign off_inc  = (r_off == OFF_MAX) ? r_off : r_off + OFFSET_BITS'(1);
    assign len_inc  = (r_len == LEN_MAX) ? r_len : r_len + stt_pkg::LEN_W'(1);
    assign ident_ch = stt_pkg::is_alpha(i_ch) || stt_pkg::is_digit(i_ch)
                      || i_ch == stt_pkg::CH_UNDER;

    always_comb begin
        for (int i = 0; i < stt_pkg::KW_MATCH_CHARS; i++) begin
            kw_word[8*(stt_pkg::KW_MATCH_CHARS-1-i) +: 8] = r_kw[i];
        end
    end

    assign id_kind = stt_pkg::ident_kind(kw_word, r_len, r_ovf);

    always_comb begin
        n_mode    = r_mode;
        n_line    = line_eff;
        n_col     = r_col;
        n_off     = r_off;
        n_tok_off = r_tok_off;
        n_tok_col = r_tok_col;
        n_len     = r_len;
        n_ovf     = r_ovf;
        kw_wr     = 1'b0;
        kw_sel    = r_len;
        handled   = 1'b0;
        newline   = 1'b0;
        a_vld     = 1'b0;
        b_vld     = 1'b0;
        res_a     = mk(id_kind, stt_pkg::STAT_OK, line_eff, r_tok_col, r_tok_off, r_len, '0);
        res_b     = mk(stt_pkg::KIND_EOF, stt_pkg::STAT_OK, line_eff, r_col, r_off, '0, '0);

        if (i_eot) begin
            b_vld = 1'b1;
            case (r_mode)
                stt_pkg::MODE_IDENT: begin
                    a_vld = 1'b1;
                end
                stt_pkg::MODE_NUMBER: begin
                    a_vld = 1'b1;
                    res_a = mk(stt_pkg::KIND_NUMBER, stt_pkg::STAT_OK, line_eff,
                               r_tok_col, r_tok_off, r_len, '0);
                end
                stt_pkg::MODE_EQ: begin
                    a_vld = 1'b1;
                    res_a = mk(stt_pkg::KIND_ASSIGN, stt_pkg::STAT_OK, line_eff,
                               r_tok_col, r_tok_off, 8'd1, '0);
                end
                stt_pkg::MODE_BANG: begin
                    a_vld = 1'b1;
                    res_a = mk(stt_pkg::KIND_BANG, stt_pkg::STAT_OK, line_eff,
                               r_tok_col, r_tok_off, 8'd1, '0);
                end
                stt_pkg::MODE_SLASH: begin
                    a_vld = 1'b1;
                    res_a = mk(stt_pkg::KIND_SLASH, stt_pkg::STAT_OK, line_eff,
                               r_tok_col, r_tok_off, 8'd1, '0);
                end
                stt_pkg::MODE_STRING: begin
                    a_vld = 1'b1;
                    b_vld = 1'b0;
                    res_a = mk(stt_pkg::KIND_EOF, stt_pkg::STAT_UNTERM, line_eff,
                               r_tok_col, r_tok_off, r_len, '0);
                end
                stt_pkg::MODE_DISCARD: begin
                    b_vld = 1'b0;
                end
                default: begin
                end
            endcase
            n_mode = stt_pkg::MODE_IDLE;
            n_col  = '0;
            n_off  = '0;
            n_len  = '0;
            n_ovf  = 1'b0;
            n_line = cfg_line;
        end else if (r_mode != stt_pkg::MODE_DISCARD) begin
            case (r_mode)
                stt_pkg::MODE_COMMENT: begin
                    if (i_ch != stt_pkg::CH_NEWLINE) begin
                        handled = 1'b1;
                    end else begin
                        n_mode = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_STRING: begin
                    handled = 1'b1;
                    if (i_ch == stt_pkg::CH_QUOTE) begin
                        a_vld  = 1'b1;
                        res_a  = mk(stt_pkg::KIND_STRING, stt_pkg::STAT_OK, line_eff,
                                    r_tok_col, r_tok_off, r_len, '0);
                        n_mode = stt_pkg::MODE_IDLE;
                    end else begin
                        n_len = len_inc;
                    end
                end
                stt_pkg::MODE_IDENT: begin
                    if (ident_ch) begin
                        if (r_len < stt_pkg::LEN_W'(KEYWORD_CHARS)) begin
                            kw_wr = 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_len   = len_inc;
                        handled = 1'b1;
                    end else begin
                        a_vld  = 1'b1;
                        n_mode = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_NUMBER: begin
                    if (stt_pkg::is_digit(i_ch)) begin
                        n_len   = len_inc;
                        handled = 1'b1;
                    end else begin
                        a_vld  = 1'b1;
                        res_a  = mk(stt_pkg::KIND_NUMBER, stt_pkg::STAT_OK, line_eff,
                                    r_tok_col, r_tok_off, r_len, '0);
                        n_mode = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_EQ, stt_pkg::MODE_BANG: begin
                    a_vld = 1'b1;
                    if (i_ch == stt_pkg::CH_EQ) begin
                        handled = 1'b1;
                        res_a = mk((r_mode == stt_pkg::MODE_EQ) ? stt_pkg::KIND_EQEQ
                                                                 : stt_pkg::KIND_NOTEQ,
                                   stt_pkg::STAT_OK, line_eff, r_tok_col, r_tok_off,
                                   8'd2, '0);
                    end else begin
                        res_a = mk((r_mode == stt_pkg::MODE_EQ) ? stt_pkg::KIND_ASSIGN
                                                                 : stt_pkg::KIND_BANG,
                                   stt_pkg::STAT_OK, line_eff, r_tok_col, r_tok_off,
                                   8'd1, '0);
                    end
                    n_mode = stt_pkg::MODE_IDLE;
                end
                stt_pkg::MODE_SLASH: begin
                    if (i_ch == stt_pkg::CH_SLASH) begin
                        n_mode  = stt_pkg::MODE_COMMENT;
                        handled = 1'b1;
                    end else begin
                        a_vld  = 1'b1;
                        res_a  = mk(stt_pkg::KIND_SLASH, stt_pkg::STAT_OK, line_eff,
                                    r_tok_col, r_tok_off, 8'd1, '0);
                        n_mode = stt_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = stt_pkg::MODE_IDLE;
                end
            endcase

            if (!handled) begin
                if (i_ch == stt_pkg::CH_SPACE) begin
                    n_mode = n_mode;
                end else if (i_ch == stt_pkg::CH_NEWLINE) begin
                    n_line  = (line_eff == LINE_MAX) ? line_eff
                                                      : line_eff + LINE_BITS'(1);
                    newline = 1'b1;
                end else if (stt_pkg::single_kind(i_ch) != stt_pkg::KIND_EOF) begin
                    b_vld = 1'b1;
                    res_b = mk(stt_pkg::single_kind(i_ch), stt_pkg::STAT_OK, line_eff,
                               r_col, r_off, 8'd1, '0);
                end else if (i_ch == stt_pkg::CH_QUOTE) begin
                    n_mode    = stt_pkg::MODE_STRING;
                    n_tok_off = off_inc;
                    n_tok_col = r_col;
                    n_len     = '0;
                end else if (i_ch == stt_pkg::CH_EQ || i_ch == stt_pkg::CH_BANG
                          || i_ch == stt_pkg::CH_SLASH || stt_pkg::is_digit(i_ch)
                          || stt_pkg::is_alpha(i_ch)) begin
                    n_tok_off = r_off;
                    n_tok_col = r_col;
                    n_len     = 8'd1;
                    if (i_ch == stt_pkg::CH_EQ) begin
                        n_mode = stt_pkg::MODE_EQ;
                    end else if (i_ch == stt_pkg::CH_BANG) begin
                        n_mode = stt_pkg::MODE_BANG;
                    end else if (i_ch == stt_pkg::CH_SLASH) begin
                        n_mode = stt_pkg::MODE_SLASH;
                    end else if (stt_pkg::is_digit(i_ch)) begin
                        n_mode = stt_pkg::MODE_NUMBER;
                    end else begin
                        n_mode = stt_pkg::MODE_IDENT;
                        kw_wr  = 1'b1;
                        kw_sel = '0;
                        n_ovf  = 1'b0;
                    end
                end else begin
                    b_vld  = 1'b1;
                    res_b  = mk(stt_pkg::KIND_EOF, stt_pkg::STAT_BAD_CHAR, line_eff,
                                r_col, r_off, 8'd1, i_ch);
                    n_mode = stt_pkg::MODE_DISCARD;
                end
            end

            n_off = off_inc;
            n_col = newline ? '0 : ((r_col == COL_MAX) ? r_col : r_col + COLUMN_BITS'(1));
        end
    end

    // Pack the results of this character: the first one always sits in the low slot.
    assign o_push  = accept && (a_vld || b_vld);
    assign o_entry = {res_b, (a_vld ? res_a : res_b), (a_vld && b_vld)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_line <= stt_pkg::FIRST_LINE_RST;
            r_mode       <= stt_pkg::MODE_IDLE;
            r_line       <= LINE_BITS'(stt_pkg::FIRST_LINE_RST);
            r_col        <= '0;
            r_off        <= '0;
            r_tok_off    <= '0;
            r_tok_col    <= '0;
            r_len        <= '0;
            r_ovf        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_first_line <= i_cfg_wdata;
            end
            if (accept) begin
                r_mode    <= n_mode;
                r_line    <= n_line;
                r_col     <= n_col;
                r_off     <= n_off;
                r_tok_off <= n_tok_off;
                r_tok_col <= n_tok_col;
                r_len     <= n_len;
                r_ovf     <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (accept && kw_wr && kw_sel == stt_pkg::LEN_W'(i)) begin
                r_kw[i] <= i_ch;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stt_queue.sv
`default_nettype none

module stt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stt_back.sv
`default_nettype none

module stt_back #(
    parameter int RES_W  = 84,
    parameter int DATA_W = 80
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [2*RES_W:0]              i_q_data,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [DATA_W-1:0]                  o_data,
    output logic [stt_pkg::TUSER_W-1:0]        o_user,
    output logic                               o_last
);

    logic             r_valid, r_last, r_pend;
    logic [RES_W-1:0] r_res, r_pend_res;
    logic             load;

    // Output register free or draining this cycle.
    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (i_q_valid) begin
                r_valid <= 1'b1;
                r_pend  <= i_q_data[0];
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_res  <= r_pend_res;
                r_last <= 1'b1;
            end else if (i_q_valid) begin
                r_res      <= i_q_data[RES_W:1];
                r_last     <= !i_q_data[0];
                r_pend_res <= i_q_data[2*RES_W:RES_W+1];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_user  = r_res[stt_pkg::TUSER_W-1:0];
    assign o_data  = DATA_W'(r_res[RES_W-1:stt_pkg::TUSER_W]);

`ifndef SYNTHESIS
    a_pend_needs_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid)
        else $error("second result held without a first one on the output");

    a_not_last_has_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> r_pend)
        else $error("non-last result shown with no follow-up held");

    a_follow_up_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !r_last) |=> (r_valid && r_last))
        else $error("follow-up result did not appear right after its first one");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/source_text_tokenizer.sv
// Streaming tokenizer: one source byte per request on s_axis, tokens out on m_axis.
// A request with s_axis_tlast set closes the text (its byte is ignored) and yields the
// pending token and an end-of-text token. Tokens carry line, start column, byte offset
// and length; an unknown byte or a string still open at end of text gives one error
// token, and bytes up to the end of text are then dropped, with no end-of-text token.
// The scanner takes one byte every cycle while its four-entry result queue has room;
// a byte that closes one token and starts a one-byte operator (for example "a+") gives
// two tokens, and the output register sends one token a cycle while m_axis_tready is
// high, so bytes with two tokens can fill the queue. Tokens pass through the result
// queue and the output register. i_cfg_we loads the first line number used for every
// following text; write it only between texts. Reset is synchronous, active low.
`default_nettype none

module source_text_tokenizer #(
    parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS   = stt_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
    parameter int DATA_W        = ((LINE_BITS + COLUMN_BITS + OFFSET_BITS
                                    + 2 * stt_pkg::LEN_W + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [stt_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [stt_pkg::CHAR_W-1:0]  s_axis_tdata,   // ch
    input  wire logic                        s_axis_tlast,   // end_of_text
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [DATA_W-1:0]                m_axis_tdata,   // line, column, value_offset,
                                                             // value_length, bad_char
    output logic [stt_pkg::TUSER_W-1:0]      m_axis_tuser,   // kind, status
    output logic                             m_axis_tlast    // last
);

    // One result: {bad_char, length, offset, column, line, status, kind}.
    localparam int RES_W = stt_pkg::TUSER_W + LINE_BITS + COLUMN_BITS + OFFSET_BITS
                           + 2 * stt_pkg::LEN_W;

    logic               q_push, q_full, q_valid, q_pop;
    logic [2*RES_W:0]   q_in, q_out;

    // Front: classify each byte and track position; push the tokens it closes.
    stt_front #(
        .LINE_BITS     (LINE_BITS),
        .COLUMN_BITS   (COLUMN_BITS),
        .OFFSET_BITS   (OFFSET_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .RES_W         (RES_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_ch        (s_axis_tdata),
        .i_eot       (s_axis_tlast),
        .o_push      (q_push),
        .o_entry     (q_in),
        .i_q_full    (q_full)
    );

    // Queue of per-byte result groups (one or two tokens each).
    stt_queue #(
        .WIDTH (2 * RES_W + 1),
        .DEPTH (stt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Back: send each group one token at a time, tlast on its final token.
    stt_back #(
        .RES_W  (RES_W),
        .DATA_W (DATA_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: tb/stt_token_checker.sv
module stt_token_checker #(
    parameter int DATA_W = 80
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [stt_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  wire logic                                 i_s_tvalid,
    input  wire logic                                 i_s_tready,
    input  wire logic [stt_pkg::CHAR_W-1:0]           i_s_tdata,
    input  wire logic                                 i_s_tlast,
    input  wire logic                                 i_m_tvalid,
    input  wire logic                                 i_m_tready,
    input  wire logic [DATA_W-1:0]                    i_m_tdata,
    input  wire logic [stt_pkg::TUSER_W-1:0]          i_m_tuser,
    input  wire logic                                 i_m_tlast,
    output int                                        o_errors,
    output int                                        o_pending,
    output int                                        o_tokens
);
    // Watches both streams of the tokenizer, predicts the tokens of every accepted
    // character request and compares them in order with the tokens that leave the block.

    localparam int LINE_W   = stt_pkg::LINE_BITS_DEF;
    localparam int COL_W    = stt_pkg::COLUMN_BITS_DEF;
    localparam int OFF_W    = stt_pkg::OFFSET_BITS_DEF;
    localparam int KW_N     = stt_pkg::KEYWORD_CHARS_DEF;
    localparam int LEN_BITS = stt_pkg::LEN_W;
    localparam int KIND_B   = stt_pkg::KIND_W;
    localparam int STAT_B   = stt_pkg::STATUS_W;
    localparam int COL_LO   = LINE_W;
    localparam int OFF_LO   = COL_LO + COL_W;
    localparam int LEN_LO   = OFF_LO + OFF_W;
    localparam int BAD_LO   = LEN_LO + LEN_BITS;
    localparam int PAD_LO   = BAD_LO + stt_pkg::CHAR_W;

    typedef struct packed {
        logic [KIND_B-1:0]          kind;
        logic [STAT_B-1:0]          status;
        logic [LINE_W-1:0]          line;
        logic [COL_W-1:0]           column;
        logic [OFF_W-1:0]           offset;
        logic [LEN_BITS-1:0]        length;
        logic [stt_pkg::CHAR_W-1:0] bad;
        logic                       last;
    } t_token;

    t_token tokens_due[$];

    // Predicted scanner state.
    stt_pkg::t_scan_mode        scan_st;
    logic [stt_pkg::CFG_W-1:0]  first_line_reg;
    logic [LINE_W-1:0]          cur_line;
    logic [COL_W-1:0]           cur_col;
    logic [OFF_W-1:0]           cur_off;
    logic [OFF_W-1:0]           tok_off;
    logic [COL_W-1:0]           tok_col;
    logic [LEN_BITS-1:0]        tok_len;
    logic [7:0]                 kw_chars[KW_N];
    logic                       kw_long;
    int                         step_tokens;

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [KIND_B-1:0] punct_kind(input logic [7:0] c);
        case (c)
            "(":     return stt_pkg::KIND_LPAREN;
            ")":     return stt_pkg::KIND_RPAREN;
            "{":     return stt_pkg::KIND_LBRACE;
            "}":     return stt_pkg::KIND_RBRACE;
            ",":     return stt_pkg::KIND_COMMA;
            "+":     return stt_pkg::KIND_PLUS;
            "-":     return stt_pkg::KIND_MINUS;
            "*":     return stt_pkg::KIND_STAR;
            "<":     return stt_pkg::KIND_LT;
            ">":     return stt_pkg::KIND_GT;
            ".":     return stt_pkg::KIND_DOT;
            ";":     return stt_pkg::KIND_SEMI;
            "&":     return stt_pkg::KIND_AMP;
            "|":     return stt_pkg::KIND_PIPE;
            "^":     return stt_pkg::KIND_CARET;
            "%":     return stt_pkg::KIND_PCT;
            ":":     return stt_pkg::KIND_COLON;
            default: return stt_pkg::KIND_EOF;
        endcase
    endfunction

    function automatic bit word_is(input string w);
        if (kw_long || tok_len != LEN_BITS'(w.len()) || w.len() > KW_N) return 1'b0;
        for (int i = 0; i < w.len(); i++) begin
            if (kw_chars[i] != w[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [KIND_B-1:0] word_kind();
        if (word_is("func")) return stt_pkg::KIND_FUNC;
        if (word_is("int") || word_is("string") || word_is("bool")) begin
            return stt_pkg::KIND_TYPE;
        end
        if (word_is("return")) return stt_pkg::KIND_RETURN;
        return stt_pkg::KIND_IDENT;
    endfunction

    function automatic string show(input t_token t);
        return $sformatf("kind %0d status %0d line %0d col %0d off %0d len %0d bad 0x%02h last %0b",
                         t.kind, t.status, t.line, t.column, t.offset, t.length, t.bad,
                         t.last);
    endfunction

    task automatic push_token(
        input logic [KIND_B-1:0]   kind,
        input logic [STAT_B-1:0]   status,
        input logic [COL_W-1:0]    col,
        input logic [OFF_W-1:0]    off,
        input logic [LEN_BITS-1:0] len,
        input logic [7:0]          bad
    );
        t_token t;
        t = '{kind, status, cur_line, col, off, len, bad, 1'b0};
        tokens_due.push_back(t);
        step_tokens++;
    endtask

    task automatic open_token(input stt_pkg::t_scan_mode m);
        scan_st = m;
        tok_off = cur_off;
        tok_col = cur_col;
        tok_len = LEN_BITS'(1);
    endtask

    task automatic scan_char(input logic [7:0] c, input logic eot);
        logic taken;
        logic newline;
        logic [KIND_B-1:0] k;
        taken       = 1'b0;
        newline     = 1'b0;
        step_tokens = 0;
        if (cur_off == '0 && scan_st == stt_pkg::MODE_IDLE) cur_line = LINE_W'(first_line_reg);
        if (eot) begin
            case (scan_st)
                stt_pkg::MODE_IDENT:
                    push_token(word_kind(), stt_pkg::STAT_OK, tok_col, tok_off, tok_len, '0);
                stt_pkg::MODE_NUMBER:
                    push_token(stt_pkg::KIND_NUMBER, stt_pkg::STAT_OK, tok_col, tok_off,
                               tok_len, '0);
                stt_pkg::MODE_EQ:
                    push_token(stt_pkg::KIND_ASSIGN, stt_pkg::STAT_OK, tok_col, tok_off,
                               LEN_BITS'(1), '0);
                stt_pkg::MODE_BANG:
                    push_token(stt_pkg::KIND_BANG, stt_pkg::STAT_OK, tok_col, tok_off,
                               LEN_BITS'(1), '0);
                stt_pkg::MODE_SLASH:
                    push_token(stt_pkg::KIND_SLASH, stt_pkg::STAT_OK, tok_col, tok_off,
                               LEN_BITS'(1), '0);
                stt_pkg::MODE_STRING:
                    push_token(stt_pkg::KIND_EOF, stt_pkg::STAT_UNTERM, tok_col, tok_off,
                               tok_len, '0);
                default: ;
            endcase
            if (scan_st != stt_pkg::MODE_STRING && scan_st != stt_pkg::MODE_DISCARD) begin
                push_token(stt_pkg::KIND_EOF, stt_pkg::STAT_OK, cur_col, cur_off, '0, '0);
            end
            scan_st  = stt_pkg::MODE_IDLE;
            cur_col  = '0;
            cur_off  = '0;
            tok_len  = '0;
            kw_long  = 1'b0;
            cur_line = LINE_W'(first_line_reg);
        end else if (scan_st != stt_pkg::MODE_DISCARD) begin
            case (scan_st)
                stt_pkg::MODE_COMMENT: begin
                    if (c != stt_pkg::CH_NEWLINE) taken = 1'b1;
                    else scan_st = stt_pkg::MODE_IDLE;
                end
                stt_pkg::MODE_STRING: begin
                    if (c == stt_pkg::CH_QUOTE) begin
                        push_token(stt_pkg::KIND_STRING, stt_pkg::STAT_OK, tok_col, tok_off,
                                   tok_len, '0);
                        scan_st = stt_pkg::MODE_IDLE;
                    end else if (tok_len != '1) begin
                        tok_len = tok_len + LEN_BITS'(1);
                    end
                    taken = 1'b1;
                end
                stt_pkg::MODE_IDENT: begin
                    if (is_letter(c) || is_num(c) || c == stt_pkg::CH_UNDER) begin
                        if (tok_len < KW_N) kw_chars[3'(tok_len)] = c;
                        else kw_long = 1'b1;
                        if (tok_len != '1) tok_len = tok_len + LEN_BITS'(1);
                        taken = 1'b1;
                    end else begin
                        push_token(word_kind(), stt_pkg::STAT_OK, tok_col, tok_off, tok_len,
                                   '0);
                        scan_st = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_NUMBER: begin
                    if (is_num(c)) begin
                        if (tok_len != '1) tok_len = tok_len + LEN_BITS'(1);
                        taken = 1'b1;
                    end else begin
                        push_token(stt_pkg::KIND_NUMBER, stt_pkg::STAT_OK, tok_col, tok_off,
                                   tok_len, '0);
                        scan_st = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_EQ, stt_pkg::MODE_BANG: begin
                    if (c == stt_pkg::CH_EQ) begin
                        push_token(scan_st == stt_pkg::MODE_EQ ? stt_pkg::KIND_EQEQ
                                                               : stt_pkg::KIND_NOTEQ,
                                   stt_pkg::STAT_OK, tok_col, tok_off, LEN_BITS'(2), '0);
                        taken = 1'b1;
                    end else begin
                        push_token(scan_st == stt_pkg::MODE_EQ ? stt_pkg::KIND_ASSIGN
                                                               : stt_pkg::KIND_BANG,
                                   stt_pkg::STAT_OK, tok_col, tok_off, LEN_BITS'(1), '0);
                    end
                    scan_st = stt_pkg::MODE_IDLE;
                end
                stt_pkg::MODE_SLASH: begin
                    if (c == stt_pkg::CH_SLASH) begin
                        scan_st = stt_pkg::MODE_COMMENT;
                        taken   = 1'b1;
                    end else begin
                        push_token(stt_pkg::KIND_SLASH, stt_pkg::STAT_OK, tok_col, tok_off,
                                   LEN_BITS'(1), '0);
                        scan_st = stt_pkg::MODE_IDLE;
                    end
                end
                default: scan_st = stt_pkg::MODE_IDLE;
            endcase

            if (!taken) begin
                k = punct_kind(c);
                if (c == stt_pkg::CH_SPACE) begin
                    // skip
                end else if (c == stt_pkg::CH_NEWLINE) begin
                    if (cur_line != '1) cur_line = cur_line + LINE_W'(1);
                    newline = 1'b1;
                end else if (k != stt_pkg::KIND_EOF) begin
                    push_token(k, stt_pkg::STAT_OK, cur_col, cur_off, LEN_BITS'(1), '0);
                end else if (c == stt_pkg::CH_EQ) begin
                    open_token(stt_pkg::MODE_EQ);
                end else if (c == stt_pkg::CH_BANG) begin
                    open_token(stt_pkg::MODE_BANG);
                end else if (c == stt_pkg::CH_SLASH) begin
                    open_token(stt_pkg::MODE_SLASH);
                end else if (c == stt_pkg::CH_QUOTE) begin
                    // string text starts after the quote
                    scan_st = stt_pkg::MODE_STRING;
                    tok_off = (cur_off == '1) ? cur_off : cur_off + OFF_W'(1);
                    tok_col = cur_col;
                    tok_len = '0;
                end else if (is_num(c)) begin
                    open_token(stt_pkg::MODE_NUMBER);
                end else if (is_letter(c)) begin
                    open_token(stt_pkg::MODE_IDENT);
                    kw_chars[0] = c;
                    kw_long     = 1'b0;
                end else begin
                    push_token(stt_pkg::KIND_EOF, stt_pkg::STAT_BAD_CHAR, cur_col, cur_off,
                               LEN_BITS'(1), c);
                    scan_st = stt_pkg::MODE_DISCARD;
                end
            end

            if (cur_off != '1) cur_off = cur_off + OFF_W'(1);
            if (newline) cur_col = '0;
            else if (cur_col != '1) cur_col = cur_col + COL_W'(1);
        end
        if (step_tokens > 0) tokens_due[tokens_due.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            tokens_due.delete();
            scan_st        = stt_pkg::MODE_IDLE;
            first_line_reg = stt_pkg::FIRST_LINE_RST;
            cur_line       = LINE_W'(stt_pkg::FIRST_LINE_RST);
            cur_col        = '0;
            cur_off        = '0;
            tok_off        = '0;
            tok_col        = '0;
            tok_len        = '0;
            kw_long        = 1'b0;
        end else begin
            if (i_cfg_we) first_line_reg = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) scan_char(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                got.kind   = i_m_tuser[0 +: KIND_B];
                got.status = i_m_tuser[KIND_B +: STAT_B];
                got.line   = i_m_tdata[0 +: LINE_W];
                got.column = i_m_tdata[COL_LO +: COL_W];
                got.offset = i_m_tdata[OFF_LO +: OFF_W];
                got.length = i_m_tdata[LEN_LO +: LEN_BITS];
                got.bad    = i_m_tdata[BAD_LO +: stt_pkg::CHAR_W];
                got.last   = i_m_tlast;
                o_tokens++;
                if (tokens_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: token with none expected\n  expected none\n  actual   %s",
                             $time, show(got));
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want || (i_m_tdata >> PAD_LO) !== '0) begin
                        o_errors++;
                        $display("%0t: token mismatch\n  expected %s\n  actual   %s pad 0x%0h",
                                 $time, show(want), show(got), i_m_tdata >> PAD_LO);
                    end
                end
            end
        end
        o_pending = tokens_due.size();
    end

endmodule

// File: tb/source_text_tokenizer_tb.sv
module source_text_tokenizer_tb;
    // Top of the tokenizer bench: drives character requests and first_line writes,
    // makes backpressure on the token side, and gives the verdict from the checker's count.

    localparam int TOK_DATA_W = ((stt_pkg::LINE_BITS_DEF + stt_pkg::COLUMN_BITS_DEF
                                  + stt_pkg::OFFSET_BITS_DEF + 2 * stt_pkg::LEN_W + 7) / 8) * 8;
    localparam int TOTAL_CHARS = 1350;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [stt_pkg::CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [stt_pkg::CHAR_W-1:0]     s_axis_tdata  = '0;
    logic                           s_axis_tlast  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [TOK_DATA_W-1:0]          m_axis_tdata;
    logic [stt_pkg::TUSER_W-1:0]    m_axis_tuser;
    logic                           m_axis_tlast;

    int chk_errors;
    int chk_pending;
    int chk_tokens;

    // Idling controls, changed between phases.
    bit src_gaps   = 1'b1;
    bit snk_stalls = 1'b1;

    int chars_sent;
    int texts_sent;
    int cfg_writes;
    int sink_hold;

    logic [7:0] text_buf[$];
    string      kw_words[8] = '{"func", "int", "string", "bool", "return",
                                "returns", "bool_", "in"};
    string      op_chars    = "(){},+-*<>.;&|^%:=!/";

    source_text_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // ch
        .s_axis_tlast  (s_axis_tlast),   // end_of_text
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // line, column, value_offset, value_length, bad_char
        .m_axis_tuser  (m_axis_tuser),   // kind, status
        .m_axis_tlast  (m_axis_tlast)    // last
    );

    stt_token_checker #(
        .DATA_W (TOK_DATA_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_tokens    (chk_tokens)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial begin
        #8000000;
        $display("source_text_tokenizer_tb: done, errors");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Token side: hold tready low for random stretches while stalls are on.
    initial begin
        sink_hold = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end else begin
                m_axis_tready <= 1'b1;
                if (snk_stalls && $urandom_range(0, 2) == 0) sink_hold = pause_len();
            end
        end
    end

    // Present one character request and hold it until taken; return at a falling edge.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        gap = src_gaps ? pause_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
        chars_sent++;
    endtask

    // Send the buffered text, then the end-of-text request with a junk byte.
    task automatic send_text();
        foreach (text_buf[i]) send_byte(text_buf[i], 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        texts_sent++;
        text_buf.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // Drain every pending token, let the pipeline settle, then load first_line.
    task automatic set_first_line(input logic [stt_pkg::CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return stt_pkg::CH_UNDER;
    endfunction

    // Printable text byte, never a quote; newline now and then.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) return stt_pkg::CH_NEWLINE;
        c = 8'($urandom_range(8'h20, 8'h7E));
        return (c == stt_pkg::CH_QUOTE) ? 8'("q") : c;
    endfunction

    // Mostly bytes the scanner rejects: tab, CR, NUL, underscore, high half, or any byte.
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 5))
            0:       return 8'h09;
            1:       return 8'h0D;
            2:       return 8'h00;
            3:       return stt_pkg::CH_UNDER;
            4:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append one well-formed lexical piece with random content.
    task automatic add_piece();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 22) begin
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            text_buf.push_back(8'($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                        : $urandom_range("A", "Z")));
            repeat (n - 1) text_buf.push_back(word_char());
        end else if (r < 32) begin
            add_str(kw_words[$urandom_range(0, 7)]);
        end else if (r < 42) begin
            repeat ($urandom_range(1, 5)) text_buf.push_back(8'($urandom_range("0", "9")));
        end else if (r < 66) begin
            if ($urandom_range(0, 6) == 0) add_str($urandom_range(0, 1) ? "==" : "!=");
            else text_buf.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        end else if (r < 78) begin
            repeat ($urandom_range(1, 3)) text_buf.push_back(stt_pkg::CH_SPACE);
        end else if (r < 84) begin
            text_buf.push_back(stt_pkg::CH_NEWLINE);
        end else if (r < 93) begin
            text_buf.push_back(stt_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6)) text_buf.push_back(text_char());
            text_buf.push_back(stt_pkg::CH_QUOTE);
        end else begin
            add_str("//");
            repeat ($urandom_range(0, 5)) begin
                text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            text_buf.push_back(stt_pkg::CH_NEWLINE);
        end
    endtask

    // Close a random text: usually cleanly, sometimes inside a string or on a bad byte.
    task automatic add_ending();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            text_buf.push_back(stt_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4)) text_buf.push_back(text_char());
        end else if (r < 16) begin
            text_buf.push_back(noise_char());
        end else if (r < 19) begin
            // bad byte followed by text that must be dropped
            text_buf.push_back(noise_char());
            repeat (2) add_piece();
        end
    endtask

    task automatic new_phase();
        case ($urandom_range(0, 4))
            0:       set_first_line('0);
            1:       set_first_line(stt_pkg::CFG_W'(1));
            2:       set_first_line('1 - stt_pkg::CFG_W'($urandom_range(0, 2)));
            default: set_first_line(stt_pkg::CFG_W'($urandom));
        endcase
        src_gaps   = ($urandom_range(0, 3) != 0);
        snk_stalls = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed texts. First one runs on the reset value of first_line:
        // identifier, operator, string holding a newline, "!=", comment, and a
        // leading underscore that is rejected and silences the rest of the text.
        add_str("a+\"x\ny\"!=//c\n_");
        send_text();
        // open string at end of text
        add_str("\"ab");
        send_text();
        // empty text gives only the end token
        send_text();
        // line counter pinned at its maximum; lone "=" resolved by end of text
        set_first_line('1);
        text_buf.push_back(stt_pkg::CH_NEWLINE);
        text_buf.push_back(stt_pkg::CH_EQ);
        send_text();

        // Long tokens: length saturation and identifiers past the keyword window.
        set_first_line('0);
        src_gaps = 1'b0;
        text_buf.push_back(8'("k"));
        repeat (259) text_buf.push_back(word_char());
        add_str(" return returnx ");
        repeat (260) text_buf.push_back(8'($urandom_range("0", "9")));
        send_text();
        text_buf.push_back(stt_pkg::CH_QUOTE);
        repeat (258) text_buf.push_back(text_char());
        text_buf.push_back(stt_pkg::CH_QUOTE);
        send_text();
        src_gaps = 1'b1;

        // Random texts up to the request budget, with first_line and idling
        // reshuffled every few texts.
        while (chars_sent < TOTAL_CHARS) begin
            if (texts_sent % 6 == 0) new_phase();
            repeat ($urandom_range(1, 12)) add_piece();
            add_ending();
            send_text();
        end

        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("covered %0d texts, %0d character requests, %0d tokens checked",
                 texts_sent, chars_sent, chk_tokens);
        $display("%0d first_line writes incl. 0 and all-ones; length saturation hit",
                 cfg_writes);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("source_text_tokenizer_tb: done, clean");
        end else begin
            $display("source_text_tokenizer_tb: done, errors");
        end
        $finish;
    end

endmodule
